/* rtl/pmq_pkg.sv */
// Shared types, constants and helpers for the priority message queue.
// Depends on nothing; every rtl file but pmq_ram refers to it by scoped names.
package pmq_pkg;

  localparam int MAX_MSG_BYTES_DEF = 128;
  localparam int QUEUE_DEPTH_DEF   = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [63:0] data_word;
    logic [3:0]  word_bytes;
    logic        last_word;
    logic [7:0]  read_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        last_out;
    logic [7:0]  byte_total;
  } rsp_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] data;
    logic [3:0]  nb;
    logic        last;
    logic [7:0]  rlen;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W1,
    ST_W2,
    ST_W_EMIT,
    ST_INS_START,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_R_HEAD,
    ST_R_ADDR,
    ST_R_DATA
  } state_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/pmq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module pmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pmq_front.sv */
// Front end: accepts request beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on pmq_pkg.
module pmq_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pmq_pkg::req_t   req,
  output logic            item_valid,
  output pmq_pkg::item_t  item,
  input  logic            item_pop
);

  pmq_pkg::item_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;
  pmq_pkg::item_t cls;

  assign req_ready  = (count != 2'd2);
  assign push       = req_valid && req_ready;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rptr];

  always_comb begin
    cls.kind = req.kind;
    cls.last = req.last_word;
    cls.rlen = req.read_length;
    cls.nb   = (req.word_bytes > 4'd8) ? 4'd8 : req.word_bytes;
    cls.data = req.data_word & pmq_pkg::byte_mask(cls.nb);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= cls;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (item_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

endmodule

/* rtl/pmq_back.sv */
// Back end: assembles write messages into the payload RAM, inserts them
// into the sorted order list and serves reads. Depends on pmq_pkg, pmq_ram.
module pmq_back #(
  parameter int MAX_MSG_BYTES = pmq_pkg::MAX_MSG_BYTES_DEF,
  parameter int QUEUE_DEPTH   = pmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  pmq_pkg::item_t item,
  output logic           item_pop,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pmq_pkg::rsp_t  rsp
);

  localparam int WORDS  = (MAX_MSG_BYTES + 7) / 8;
  localparam int LEN_W  = $clog2(MAX_MSG_BYTES + 1);
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int KW     = $clog2(WORDS + 1);
  localparam int PDEPTH = QUEUE_DEPTH * WORDS;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int ENT_W  = 8 + LEN_W + SLOT_W;

  pmq_pkg::state_t state;
  pmq_pkg::state_t state_next;

  logic [SLOT_W-1:0]      head;
  logic [CNT_W-1:0]       count;
  logic [QUEUE_DEPTH-1:0] free;
  logic                   active;
  logic                   dropped;
  logic [LEN_W-1:0]       abytes;
  logic [SLOT_W-1:0]      aslot;
  logic [7:0]             aprio;
  logic [63:0]            acc;
  logic [63:0]            hi_word;
  logic [PAW-1:0]         spill_addr;
  logic [ENT_W-1:0]       new_ent;
  logic [CNT_W-1:0]       ins_j;
  logic [SLOT_W-1:0]      rslot;
  logic [LEN_W-1:0]       rlen;
  logic [LEN_W-1:0]       rn;
  logic [KW-1:0]          rk;
  logic [KW-1:0]          rnwords;

  logic           pw_we;
  logic [PAW-1:0] pw_addr;
  logic [63:0]    pw_data;
  logic [PAW-1:0] pr_addr;
  logic [63:0]    pr_q;

  logic              ow_we;
  logic [SLOT_W-1:0] ow_addr;
  logic [ENT_W-1:0]  ow_data;
  logic [SLOT_W-1:0] or_addr;
  logic [ENT_W-1:0]  or_q;

  logic              emit;
  pmq_pkg::rsp_t     emit_data;
  logic              out_free;

  logic              found;
  logic [SLOT_W-1:0] free_idx;
  logic              alloc;
  logic              drop_now;
  logic [SLOT_W-1:0] use_slot;
  logic [LEN_W-1:0]  base_bytes;
  logic [3:0]        take;
  logic [3:0]        fill;
  logic [127:0]      combined;
  logic [LEN_W-1:0]  new_bytes;
  logic              spill;
  logic [PAW-1:0]    low_addr;
  logic              ins_move;
  logic              r_last;
  logic [LEN_W-1:0]  n_clamped;
  logic [KW-1:0]     n_words;

  function automatic logic [SLOT_W-1:0] abs_pos(input logic [SLOT_W-1:0] h,
                                                input int rel);
    int s;
    s = int'(h) + rel;
    if (s >= QUEUE_DEPTH) begin
      s = s - QUEUE_DEPTH;
    end
    return SLOT_W'(s);
  endfunction

  function automatic logic [PAW-1:0] paddr(input logic [SLOT_W-1:0] s, input int k);
    return PAW'(int'(s) * WORDS + k);
  endfunction

  pmq_ram #(.WIDTH(64), .DEPTH(PDEPTH)) u_payload (
    .clk   (clk),
    .we    (pw_we),
    .waddr (pw_addr),
    .wdata (pw_data),
    .raddr (pr_addr),
    .rdata (pr_q)
  );

  pmq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_order (
    .clk   (clk),
    .we    (ow_we),
    .waddr (ow_addr),
    .wdata (ow_data),
    .raddr (or_addr),
    .rdata (or_q)
  );

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!found && free[i]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    alloc      = !active && !dropped && (item.nb != 4'd0) && found;
    drop_now   = !active && !dropped && (item.nb != 4'd0) && !found;
    use_slot   = alloc ? free_idx : aslot;
    base_bytes = alloc ? '0 : abytes;
    take       = 4'd0;
    if (active || alloc) begin
      if (int'(item.nb) > MAX_MSG_BYTES - int'(base_bytes)) begin
        take = 4'(MAX_MSG_BYTES - int'(base_bytes));
      end else begin
        take = item.nb;
      end
    end
    fill      = {1'b0, base_bytes[2:0]} + take;
    combined  = {64'd0, (alloc ? 64'd0 : acc)} | ({64'd0, item.data & pmq_pkg::byte_mask(take)}
                << {base_bytes[2:0], 3'b000});
    new_bytes = base_bytes + LEN_W'(take);
    spill     = fill > 4'd8;
    low_addr  = paddr(use_slot, int'(base_bytes >> 3));
  end

  always_comb begin
    n_clamped = (int'(item.rlen) > MAX_MSG_BYTES) ? LEN_W'(MAX_MSG_BYTES)
                                                  : LEN_W'(item.rlen);
    n_words   = (n_clamped == '0) ? KW'(1) : KW'((int'(n_clamped) + 7) / 8);
    ins_move  = or_q[ENT_W-1 -: 8] < new_ent[ENT_W-1 -: 8];
    r_last    = (rk == rnwords - KW'(1));
  end

  always_comb begin
    int base;
    int cnt;
    int vcnt;
    base = int'(rk) * 8;
    cnt  = int'(rn) - base;
    if (cnt > 8) begin
      cnt = 8;
    end
    if (cnt < 0) begin
      cnt = 0;
    end
    vcnt = int'(rlen) - base;
    if (vcnt > cnt) begin
      vcnt = cnt;
    end
    if (vcnt < 0) begin
      vcnt = 0;
    end
    emit_data = '0;
    case (state)
      pmq_pkg::ST_IDLE: begin
        emit_data.status   = pmq_pkg::STATUS_EMPTY;
        emit_data.last_out = 1'b1;
      end
      pmq_pkg::ST_W_EMIT: begin
        emit_data.status     = dropped ? pmq_pkg::STATUS_FULL : pmq_pkg::STATUS_OK;
        emit_data.last_out   = 1'b1;
        emit_data.byte_total = dropped ? 8'd0 : 8'(abytes);
      end
      pmq_pkg::ST_R_DATA: begin
        emit_data.status     = pmq_pkg::STATUS_OK;
        emit_data.out_word   = pr_q & pmq_pkg::byte_mask(4'(vcnt));
        emit_data.out_bytes  = 4'(cnt);
        emit_data.last_out   = r_last;
        emit_data.byte_total = 8'(rn);
      end
      default: begin
        emit_data = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      pmq_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item.kind == pmq_pkg::KIND_WRITE) begin
            state_next = pmq_pkg::ST_W1;
          end else if (count != '0) begin
            state_next = pmq_pkg::ST_R_HEAD;
          end
        end
      end
      pmq_pkg::ST_W1: begin
        state_next = spill ? pmq_pkg::ST_W2 : pmq_pkg::ST_W_EMIT;
      end
      pmq_pkg::ST_W2: begin
        state_next = pmq_pkg::ST_W_EMIT;
      end
      pmq_pkg::ST_W_EMIT: begin
        if (out_free) begin
          if (item.last && active) begin
            state_next = pmq_pkg::ST_INS_START;
          end else begin
            state_next = pmq_pkg::ST_IDLE;
          end
        end
      end
      pmq_pkg::ST_INS_START: begin
        state_next = (ins_j == '0) ? pmq_pkg::ST_INS_PUT : pmq_pkg::ST_INS_CMP;
      end
      pmq_pkg::ST_INS_CMP: begin
        if (!ins_move) begin
          state_next = pmq_pkg::ST_IDLE;
        end else if (ins_j == CNT_W'(1)) begin
          state_next = pmq_pkg::ST_INS_PUT;
        end
      end
      pmq_pkg::ST_INS_PUT: begin
        state_next = pmq_pkg::ST_IDLE;
      end
      pmq_pkg::ST_R_HEAD: begin
        state_next = pmq_pkg::ST_R_ADDR;
      end
      pmq_pkg::ST_R_ADDR: begin
        state_next = pmq_pkg::ST_R_DATA;
      end
      pmq_pkg::ST_R_DATA: begin
        if (out_free) begin
          state_next = r_last ? pmq_pkg::ST_IDLE : pmq_pkg::ST_R_ADDR;
        end
      end
      default: begin
        state_next = pmq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    item_pop = 1'b0;
    pw_we    = 1'b0;
    pw_addr  = low_addr;
    pw_data  = combined[63:0];
    pr_addr  = paddr(rslot, int'(rk));
    ow_we    = 1'b0;
    ow_addr  = abs_pos(head, int'(ins_j));
    ow_data  = new_ent;
    or_addr  = head;
    case (state)
      pmq_pkg::ST_IDLE: begin
        if (item_valid && item.kind == pmq_pkg::KIND_READ && count == '0 && out_free) begin
          emit     = 1'b1;
          item_pop = 1'b1;
        end
      end
      pmq_pkg::ST_W1: begin
        pw_we = (take != 4'd0);
      end
      pmq_pkg::ST_W2: begin
        pw_we   = 1'b1;
        pw_addr = spill_addr;
        pw_data = hi_word;
      end
      pmq_pkg::ST_W_EMIT: begin
        if (out_free) begin
          emit     = 1'b1;
          item_pop = 1'b1;
        end
      end
      pmq_pkg::ST_INS_START: begin
        or_addr = abs_pos(head, (ins_j == '0) ? 0 : int'(ins_j) - 1);
      end
      pmq_pkg::ST_INS_CMP: begin
        ow_we   = 1'b1;
        ow_data = ins_move ? or_q : new_ent;
        or_addr = abs_pos(head, (ins_j < CNT_W'(2)) ? 0 : int'(ins_j) - 2);
      end
      pmq_pkg::ST_INS_PUT: begin
        ow_we = 1'b1;
      end
      pmq_pkg::ST_R_DATA: begin
        if (out_free) begin
          emit     = 1'b1;
          item_pop = r_last;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_data;
    end
    case (state)
      pmq_pkg::ST_W1: begin
        hi_word    <= combined[127:64];
        spill_addr <= paddr(use_slot, int'(base_bytes >> 3) + 1);
        if (alloc) begin
          aprio <= item.data[7:0];
        end
        if (take != 4'd0) begin
          acc <= (fill >= 4'd8) ? combined[127:64] : combined[63:0];
        end
      end
      pmq_pkg::ST_W_EMIT: begin
        new_ent <= {aprio, abytes, aslot};
        ins_j   <= count;
      end
      pmq_pkg::ST_INS_CMP: begin
        ins_j <= ins_j - CNT_W'(1);
      end
      pmq_pkg::ST_IDLE: begin
        rn      <= n_clamped;
        rnwords <= n_words;
        rk      <= '0;
      end
      pmq_pkg::ST_R_HEAD: begin
        rslot <= or_q[SLOT_W-1:0];
        rlen  <= or_q[SLOT_W +: LEN_W];
      end
      pmq_pkg::ST_R_DATA: begin
        if (out_free) begin
          rk <= rk + KW'(1);
        end
      end
      default: begin
      end
    endcase
    if (rst) begin
      state     <= pmq_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
      head      <= '0;
      count     <= '0;
      free      <= '1;
      active    <= 1'b0;
      dropped   <= 1'b0;
      abytes    <= '0;
      aslot     <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        pmq_pkg::ST_W1: begin
          abytes <= new_bytes;
          aslot  <= use_slot;
          if (alloc) begin
            active         <= 1'b1;
            free[free_idx] <= 1'b0;
          end
          if (drop_now) begin
            dropped <= 1'b1;
          end
        end
        pmq_pkg::ST_W_EMIT: begin
          if (out_free && item.last) begin
            active  <= 1'b0;
            dropped <= 1'b0;
            abytes  <= '0;
            aslot   <= '0;
          end
        end
        pmq_pkg::ST_INS_CMP: begin
          if (!ins_move) begin
            count <= count + CNT_W'(1);
          end
        end
        pmq_pkg::ST_INS_PUT: begin
          count <= count + CNT_W'(1);
        end
        pmq_pkg::ST_R_DATA: begin
          if (out_free && r_last) begin
            head        <= abs_pos(head, 1);
            count       <= count - CNT_W'(1);
            free[rslot] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/priority_message_queue.sv */
// Priority message queue: a write beat passes W1, W2 if it spills, and W_EMIT
// (waiting for the output); a final beat walks INS_START, INS_CMP per entry
// passed, INS_PUT at the head. A read walks R_HEAD, then R_ADDR, R_DATA per word.
// rst is synchronous: control state clears, the queue is empty, RAMs keep data.
// Depends on pmq_pkg, pmq_front, pmq_back and pmq_ram.
module priority_message_queue #(
  parameter int MAX_MSG_BYTES = pmq_pkg::MAX_MSG_BYTES_DEF,
  parameter int QUEUE_DEPTH   = pmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pmq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pmq_pkg::rsp_t rsp
);

  logic           item_valid;
  logic           item_pop;
  pmq_pkg::item_t item;

  pmq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  pmq_back #(
    .MAX_MSG_BYTES (MAX_MSG_BYTES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
